// File: design/avcc_pkg.sv
// avcc_pkg: shared constants, register indexes and types for the access-unit scanner
// no dependencies; imported by the interfaces and every module of the block

package avcc_pkg;

   // byte position counter width and its saturation value
   localparam int POS_BITS = 17;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   // widths of register and result fields
   localparam int CFG_BITS   = 17;
   localparam int UNIT_BITS  = 4;
   localparam int FLEN_BITS  = 17;
   localparam int DATA_BITS  = 8;
   localparam int CSR_IDX_BITS = 2;

   // unit end offsets hold a position plus a length
   localparam int END_BITS = ((POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS) + 1;

   // length prefix is four bytes, accumulated into a full word
   localparam int PREFIX_BYTES = 4;
   localparam int ACC_BITS     = PREFIX_BYTES * DATA_BITS;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_BUFFER_CAP = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_LENGTH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_UNITS  = 2'd2;

   // register reset values
   localparam logic [CFG_BITS-1:0]  CAP_RESET       = 17'd120000;
   localparam logic [CFG_BITS-1:0]  MAX_LEN_RESET   = 17'd120000;
   localparam logic [UNIT_BITS-1:0] MAX_UNITS_RESET = 4'd8;

   // nal header fields
   localparam int HDR_FORBIDDEN_BIT = 7;
   localparam int HDR_TYPE_BITS     = 5;
   localparam logic [HDR_TYPE_BITS-1:0] NAL_TYPE_SLICE = 5'd1;
   localparam logic [HDR_TYPE_BITS-1:0] NAL_TYPE_IDR   = 5'd5;
   localparam logic [ACC_BITS-1:0]      MIN_UNIT_LENGTH = 32'd2;

   typedef struct packed {
      logic [CFG_BITS-1:0]  buffer_cap;
      logic [CFG_BITS-1:0]  max_length;
      logic [UNIT_BITS-1:0] max_units;
   } cfg_type;

   typedef struct packed {
      logic                 frame_ok;
      logic [FLEN_BITS-1:0] frame_length;
      logic [UNIT_BITS-1:0] units_seen;
   } rsp_type;

endpackage

// File: design/avcc_if.sv
// avcc channel interfaces: byte input, frame result and register write
// depends on avcc_pkg for field widths

interface avcc_req_if;
   import avcc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] data_byte;
   logic                 last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface avcc_rsp_if;
   import avcc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 frame_ok;
   logic [FLEN_BITS-1:0] frame_length;
   logic [UNIT_BITS-1:0] units_seen;
   modport source (output valid, output frame_ok, output frame_length, output units_seen,
                   input ready);
   modport sink   (input valid, input frame_ok, input frame_length, input units_seen,
                   output ready);
endinterface

interface avcc_csr_if;
   import avcc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CFG_BITS-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/avcc_csr.sv
// avcc_csr: configuration registers of the scanner, written through the csr channel
// depends on avcc_pkg for register indexes, reset values and cfg_type

module avcc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_valid,
   output logic                              wr_ready,
   input  logic [avcc_pkg::CSR_IDX_BITS-1:0] wr_index,
   input  logic [avcc_pkg::CFG_BITS-1:0]     wr_data,
   output avcc_pkg::cfg_type                 cfg
);
   import avcc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // always ready; a write to an unknown index is dropped
   assign wr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (wr_index)
            CSR_BUFFER_CAP: cfg_in.buffer_cap = wr_data;
            CSR_MAX_LENGTH: cfg_in.max_length = wr_data;
            CSR_MAX_UNITS:  cfg_in.max_units  = wr_data[UNIT_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_cap <= CAP_RESET;
         cfg_ff.max_length <= MAX_LEN_RESET;
         cfg_ff.max_units  <= MAX_UNITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/avcc_scan_core.sv
// avcc_scan_core: input register plus the per-byte nal walk and scan state
// depends on avcc_pkg for widths, header constants, cfg_type and rsp_type

module avcc_scan_core (
   input  logic                           clock,
   input  logic                           reset,
   input  avcc_pkg::cfg_type              cfg,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [avcc_pkg::DATA_BITS-1:0] in_byte,
   input  logic                           in_last,
   input  logic                           out_free,
   output logic                           push,
   output avcc_pkg::rsp_type              push_rsp
);
   import avcc_pkg::*;

   // input register
   logic                 hold_valid_ff, hold_valid_in;
   logic [DATA_BITS-1:0] hold_byte_ff;
   logic                 hold_last_ff;

   // scan state
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [END_BITS-1:0]  next_prefix_ff, next_prefix_in;
   logic [ACC_BITS-1:0]  len_acc_ff, len_acc_in;
   logic [UNIT_BITS-1:0] units_ff, units_in;
   logic                 stopped_ff, stopped_in;
   logic                 found_ff, found_in;
   logic [END_BITS-1:0]  slice_end_ff, slice_end_in;

   logic                 advance;
   logic                 counted;
   logic                 parse;
   logic [END_BITS-1:0]  offset;
   logic [END_BITS-1:0]  unit_end;
   logic [UNIT_BITS-1:0] units_inc;
   logic [HDR_TYPE_BITS-1:0] hdr_type;
   logic [POS_BITS-1:0]  pos_step;
   logic [END_BITS-1:0]  size;
   logic                 ok;

   // held beat moves on unless it is a last byte facing a full result slot
   assign advance       = hold_valid_ff && (!hold_last_ff || out_free);
   assign in_ready      = !hold_valid_ff || advance;
   assign hold_valid_in = in_valid ? 1'b1 : (advance ? 1'b0 : hold_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         hold_byte_ff <= in_byte;
         hold_last_ff <= in_last;
      end
   end

   // position counter and parse window
   assign counted  = pos_ff != POS_MAX;
   assign pos_step = counted ? pos_ff + 1'b1 : pos_ff;
   assign parse    = counted && (END_BITS'(pos_ff) < END_BITS'(cfg.buffer_cap)) &&
                     !stopped_ff && (END_BITS'(pos_ff) >= next_prefix_ff);
   assign offset   = END_BITS'(pos_ff) - next_prefix_ff;
   assign unit_end = END_BITS'(pos_ff) + END_BITS'(len_acc_ff[CFG_BITS-1:0]);
   assign units_inc = units_ff + 1'b1;
   assign hdr_type  = hold_byte_ff[HDR_TYPE_BITS-1:0];

   // prefix accumulation and header checks
   always_comb begin
      pos_in         = pos_ff;
      next_prefix_in = next_prefix_ff;
      len_acc_in     = len_acc_ff;
      units_in       = units_ff;
      stopped_in     = stopped_ff;
      found_in       = found_ff;
      slice_end_in   = slice_end_ff;
      if (advance) begin
         pos_in = pos_step;
         if (parse && offset < END_BITS'(PREFIX_BYTES)) begin
            len_acc_in = {len_acc_ff[ACC_BITS-DATA_BITS-1:0], hold_byte_ff};
         end else if (parse && offset == END_BITS'(PREFIX_BYTES)) begin
            len_acc_in = '0;
            priority if (units_ff >= cfg.max_units) begin
               stopped_in = 1'b1;
            end else if (len_acc_ff < MIN_UNIT_LENGTH ||
                         len_acc_ff > ACC_BITS'(cfg.max_length)) begin
               stopped_in = 1'b1;
            end else if (hold_byte_ff[HDR_FORBIDDEN_BIT]) begin
               stopped_in = 1'b1;
            end else begin
               next_prefix_in = unit_end;
               units_in       = units_inc;
               if (hdr_type == NAL_TYPE_SLICE || hdr_type == NAL_TYPE_IDR) begin
                  found_in     = 1'b1;
                  slice_end_in = unit_end;
                  stopped_in   = 1'b1;
               end else if (units_inc >= cfg.max_units) begin
                  stopped_in = 1'b1;
               end
            end
         end
      end
   end

   // frame verdict on the last byte, from the updated state
   assign size = (END_BITS'(pos_in) < END_BITS'(cfg.buffer_cap)) ?
                 END_BITS'(pos_in) : END_BITS'(cfg.buffer_cap);
   assign ok   = found_in && (slice_end_in != '0) && (slice_end_in <= size);

   assign push                  = advance && hold_last_ff;
   assign push_rsp.frame_ok     = ok;
   assign push_rsp.frame_length = ok ? slice_end_in[FLEN_BITS-1:0] : '0;
   assign push_rsp.units_seen   = units_in;

   // state register; a last byte starts the next buffer afresh
   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff         <= '0;
         next_prefix_ff <= '0;
         len_acc_ff     <= '0;
         units_ff       <= '0;
         stopped_ff     <= 1'b0;
         found_ff       <= 1'b0;
         slice_end_ff   <= '0;
      end else begin
         pos_ff         <= pos_in;
         next_prefix_ff <= next_prefix_in;
         len_acc_ff     <= len_acc_in;
         units_ff       <= units_in;
         stopped_ff     <= stopped_in;
         found_ff       <= found_in;
         slice_end_ff   <= slice_end_in;
      end
   end

endmodule

// File: design/avcc_rsp_buf.sv
// avcc_rsp_buf: result register that holds one frame verdict until it is taken
// depends on avcc_pkg for rsp_type

module avcc_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  avcc_pkg::rsp_type push_rsp,
   output logic              free,
   output logic              out_valid,
   input  logic              out_ready,
   output avcc_pkg::rsp_type out_rsp
);
   import avcc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type rsp_ff;

   // slot is free when empty or drained this cycle
   assign free     = !valid_ff || out_ready;
   assign valid_in = push ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_ff <= push_rsp;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// File: design/avcc_access_unit_scanner.sv
// avcc_access_unit_scanner: top level of the avcc nal length-prefix scanner
// depends on avcc_pkg, the avcc channel interfaces, avcc_csr, avcc_scan_core, avcc_rsp_buf
//
//   channel   role   beat
//   req_bus   sink   data_byte, last_byte
//   rsp_bus   source frame_ok, frame_length, units_seen (one per last byte)
//   csr_bus   sink   index, data (register write, always ready)
//
// one byte per cycle sustained unless a last byte waits on a full result slot; each
// byte is held in the input register, its scan update is made from there, and the
// verdict for a last byte is registered in the result register that drives rsp_bus.
// synchronous active-high reset clears scan state and loads register defaults.
// a stalled verdict holds its last byte in the input register, and input stalls behind it.

module avcc_access_unit_scanner (
   input  logic        clock,
   input  logic        reset,
   avcc_req_if.sink    req_bus,
   avcc_rsp_if.source  rsp_bus,
   avcc_csr_if.sink    csr_bus
);
   import avcc_pkg::*;

   cfg_type cfg;
   rsp_type push_rsp;
   rsp_type out_rsp;
   logic    push;
   logic    out_free;

   // configuration registers
   avcc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_ready (csr_bus.ready),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   // byte walk
   avcc_scan_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .in_byte  (req_bus.data_byte),
      .in_last  (req_bus.last_byte),
      .out_free (out_free),
      .push     (push),
      .push_rsp (push_rsp)
   );

   // result register
   avcc_rsp_buf u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rsp  (push_rsp),
      .free      (out_free),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_rsp   (out_rsp)
   );

   assign rsp_bus.frame_ok     = out_rsp.frame_ok;
   assign rsp_bus.frame_length = out_rsp.frame_length;
   assign rsp_bus.units_seen   = out_rsp.units_seen;

`ifndef SYNTHESIS
   // a failed frame always reports a zero length
   a_fail_zero_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.frame_ok) |-> (rsp_bus.frame_length == '0))
      else $error("failed frame with nonzero length");

   // a good frame ends past at least one prefix and header
   a_ok_nonzero_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.frame_ok) |-> (rsp_bus.frame_length != '0))
      else $error("good frame with zero length");

   // a verdict is only written into a free result slot
   a_push_free : assert property (@(posedge clock) disable iff (reset)
      push |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("verdict overwrote a pending result");

   // with no pending result the input side never stalls
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("input stalled with an empty result slot");
`endif

endmodule
